// ===== design/rvex_pkg.sv =====
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared opcodes, operation codes and the stage-to-stage control bundle for the
// RV64IM execute pipeline.
// ----------------------------------------------------------------------------
package rvex_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_IMM32  = 7'h1b;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_REG32  = 7'h3b;
  localparam logic [6:0] OP_FENCE  = 7'h0f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
  localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INSN_MRET   = 32'h3020_0073;

  localparam logic [1:0] TRAP_NONE    = 2'd0;
  localparam logic [1:0] TRAP_EBREAK  = 2'd1;
  localparam logic [1:0] TRAP_ILLEGAL = 2'd2;
  localparam logic [1:0] TRAP_SYSTEM  = 2'd3;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam int unsigned DivSteps = 64;

  // result source selected in the last stage
  typedef enum logic [2:0] {
    RES_ALU  = 3'd0,
    RES_MULL = 3'd1,
    RES_MULH = 3'd2,
    RES_DIV  = 3'd3,
    RES_REM  = 3'd4
  } res_sel_e;

  // control that travels with each item
  typedef struct packed {
    logic [4:0]  rd;
    logic        wr;
    logic        rd_out;
    logic [63:0] alu_val;
    logic [63:0] npc;
    logic [1:0]  kind;
    logic [1:0]  size;
    logic        uns;
    logic [63:0] addr;
    logic [63:0] sdata;
    logic [1:0]  trap;
    res_sel_e    sel;
    logic        word;
    logic [1:0]  mulh_mode; // 0 none/hu, 1 h, 2 hsu
    logic        div_signed;
    logic [63:0] op_a;
    logic [63:0] op_b;
  } ctrl_t;

endpackage

// ===== design/rvex_decode.sv =====
// ----------------------------------------------------------------------------
// rvex_decode
// Instruction decode, immediates, ALU, branch and memory request, combinational.
// ----------------------------------------------------------------------------
module rvex_decode (
  input  logic [31:0]          insn_i,
  input  logic [63:0]          pc_i,
  input  logic [63:0]          a_i,
  input  logic [63:0]          b_i,
  output rvex_pkg::ctrl_t      ctrl_o
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  hi6;
  logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [63:0] pc4, a_w;
  logic [5:0]  sh6;
  logic [4:0]  sh5;
  logic        lt_s, lt_u, taken;
  logic [31:0] w_res;

  assign opc = insn_i[6:0];
  assign f3  = insn_i[14:12];
  assign f7  = insn_i[31:25];
  assign hi6 = insn_i[31:26];
  assign imm_i = {{52{insn_i[31]}}, insn_i[31:20]};
  assign imm_s = {{52{insn_i[31]}}, insn_i[31:25], insn_i[11:7]};
  assign imm_b = {{51{insn_i[31]}}, insn_i[31], insn_i[7], insn_i[30:25], insn_i[11:8], 1'b0};
  assign imm_u = {{32{insn_i[31]}}, insn_i[31:12], 12'd0};
  assign imm_j = {{43{insn_i[31]}}, insn_i[31], insn_i[19:12], insn_i[20], insn_i[30:21],
                  1'b0};
  assign pc4 = pc_i + 64'd4;
  assign a_w = {{32{a_i[31]}}, a_i[31:0]};

  // decode and simple datapath
  always_comb begin
    rvex_pkg::ctrl_t c;
    c = '0;
    c.npc = pc4;
    c.rd = insn_i[11:7];
    c.sel = rvex_pkg::RES_ALU;
    c.op_a = a_i;
    c.op_b = b_i;
    sh6 = 6'd0;
    sh5 = 5'd0;
    lt_s = 1'b0;
    lt_u = 1'b0;
    taken = 1'b0;
    w_res = 32'd0;
    case (opc)
      rvex_pkg::OP_LUI: begin
        c.wr = 1'b1; c.alu_val = imm_u;
      end
      rvex_pkg::OP_AUIPC: begin
        c.wr = 1'b1; c.alu_val = pc_i + imm_u;
      end
      rvex_pkg::OP_JAL: begin
        c.wr = 1'b1; c.alu_val = pc4; c.npc = pc_i + imm_j;
      end
      rvex_pkg::OP_JALR: begin
        if (f3 != 3'd0) begin
          c.trap = rvex_pkg::TRAP_ILLEGAL;
        end else begin
          c.wr = 1'b1; c.alu_val = pc4;
          c.npc = (a_i + imm_i) & ~64'd1;
        end
      end
      rvex_pkg::OP_BRANCH: begin
        lt_s = $signed(a_i) < $signed(b_i);
        lt_u = a_i < b_i;
        case (f3)
          3'd0: taken = a_i == b_i;
          3'd1: taken = a_i != b_i;
          3'd4: taken = lt_s;
          3'd5: taken = !lt_s;
          3'd6: taken = lt_u;
          3'd7: taken = !lt_u;
          default: c.trap = rvex_pkg::TRAP_ILLEGAL;
        endcase
        if (taken) c.npc = pc_i + imm_b;
      end
      rvex_pkg::OP_LOAD: begin
        if (f3 == 3'd7) begin
          c.trap = rvex_pkg::TRAP_ILLEGAL;
        end else begin
          c.kind = rvex_pkg::MEM_LOAD; c.size = f3[1:0]; c.uns = f3[2];
          c.addr = a_i + imm_i;
        end
      end
      rvex_pkg::OP_STORE: begin
        if (f3[2]) begin
          c.trap = rvex_pkg::TRAP_ILLEGAL;
        end else begin
          c.kind = rvex_pkg::MEM_STORE; c.size = f3[1:0];
          c.addr = a_i + imm_s;
          case (f3[1:0])
            2'd0: c.sdata = {56'd0, b_i[7:0]};
            2'd1: c.sdata = {48'd0, b_i[15:0]};
            2'd2: c.sdata = {32'd0, b_i[31:0]};
            default: c.sdata = b_i;
          endcase
        end
      end
      rvex_pkg::OP_IMM: begin
        c.wr = 1'b1;
        sh6 = insn_i[25:20];
        case (f3)
          3'd0: c.alu_val = a_i + imm_i;
          3'd1: begin
            if (hi6 != 6'd0) c.trap = rvex_pkg::TRAP_ILLEGAL;
            else c.alu_val = a_i << sh6;
          end
          3'd2: c.alu_val = {63'd0, $signed(a_i) < $signed(imm_i)};
          3'd3: c.alu_val = {63'd0, a_i < imm_i};
          3'd4: c.alu_val = a_i ^ imm_i;
          3'd5: begin
            if (hi6 == 6'd0) c.alu_val = a_i >> sh6;
            else if (hi6 == 6'h10) c.alu_val = $unsigned($signed(a_i) >>> sh6);
            else c.trap = rvex_pkg::TRAP_ILLEGAL;
          end
          3'd6: c.alu_val = a_i | imm_i;
          default: c.alu_val = a_i & imm_i;
        endcase
      end
      rvex_pkg::OP_IMM32: begin
        c.wr = 1'b1;
        sh5 = insn_i[24:20];
        if (f3 == 3'd0) w_res = a_i[31:0] + imm_i[31:0];
        else if (f3 == 3'd1 && f7 == 7'd0) w_res = a_i[31:0] << sh5;
        else if (f3 == 3'd5 && f7 == 7'd0) w_res = a_i[31:0] >> sh5;
        else if (f3 == 3'd5 && f7 == 7'h20) w_res = $unsigned($signed(a_i[31:0]) >>> sh5);
        else c.trap = rvex_pkg::TRAP_ILLEGAL;
        c.alu_val = {{32{w_res[31]}}, w_res};
      end
      rvex_pkg::OP_REG: begin
        c.wr = 1'b1;
        sh6 = b_i[5:0];
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: c.alu_val = a_i + b_i;
            3'd1: c.alu_val = a_i << sh6;
            3'd2: c.alu_val = {63'd0, $signed(a_i) < $signed(b_i)};
            3'd3: c.alu_val = {63'd0, a_i < b_i};
            3'd4: c.alu_val = a_i ^ b_i;
            3'd5: c.alu_val = a_i >> sh6;
            3'd6: c.alu_val = a_i | b_i;
            default: c.alu_val = a_i & b_i;
          endcase
        end else if (f7 == 7'h20 && f3 == 3'd0) begin
          c.alu_val = a_i - b_i;
        end else if (f7 == 7'h20 && f3 == 3'd5) begin
          c.alu_val = $unsigned($signed(a_i) >>> sh6);
        end else if (f7 == 7'd1) begin
          case (f3)
            3'd0: c.sel = rvex_pkg::RES_MULL;
            3'd1: begin c.sel = rvex_pkg::RES_MULH; c.mulh_mode = 2'd1; end
            3'd2: begin c.sel = rvex_pkg::RES_MULH; c.mulh_mode = 2'd2; end
            3'd3: c.sel = rvex_pkg::RES_MULH;
            3'd4: begin c.sel = rvex_pkg::RES_DIV; c.div_signed = 1'b1; end
            3'd5: c.sel = rvex_pkg::RES_DIV;
            3'd6: begin c.sel = rvex_pkg::RES_REM; c.div_signed = 1'b1; end
            default: c.sel = rvex_pkg::RES_REM;
          endcase
        end else begin
          c.trap = rvex_pkg::TRAP_ILLEGAL;
        end
      end
      rvex_pkg::OP_REG32: begin
        c.wr = 1'b1;
        c.word = 1'b1;
        sh5 = b_i[4:0];
        if (f7 == 7'd0 && f3 == 3'd0) w_res = a_i[31:0] + b_i[31:0];
        else if (f7 == 7'd0 && f3 == 3'd1) w_res = a_i[31:0] << sh5;
        else if (f7 == 7'd0 && f3 == 3'd5) w_res = a_i[31:0] >> sh5;
        else if (f7 == 7'h20 && f3 == 3'd0) w_res = a_i[31:0] - b_i[31:0];
        else if (f7 == 7'h20 && f3 == 3'd5) w_res = $unsigned($signed(a_w[31:0]) >>> sh5);
        else if (f7 == 7'd1 && f3 == 3'd0) c.sel = rvex_pkg::RES_MULL;
        else if (f7 == 7'd1 && f3 == 3'd4) begin
          c.sel = rvex_pkg::RES_DIV; c.div_signed = 1'b1;
        end else if (f7 == 7'd1 && f3 == 3'd5) c.sel = rvex_pkg::RES_DIV;
        else if (f7 == 7'd1 && f3 == 3'd6) begin
          c.sel = rvex_pkg::RES_REM; c.div_signed = 1'b1;
        end else if (f7 == 7'd1 && f3 == 3'd7) c.sel = rvex_pkg::RES_REM;
        else c.trap = rvex_pkg::TRAP_ILLEGAL;
        c.alu_val = {{32{w_res[31]}}, w_res};
        // word divide operands are extended up front
        if (f3[2]) begin
          if (f3[0]) begin
            c.op_a = {32'd0, a_i[31:0]};
            c.op_b = {32'd0, b_i[31:0]};
          end else begin
            c.op_a = a_w;
            c.op_b = {{32{b_i[31]}}, b_i[31:0]};
          end
        end
      end
      rvex_pkg::OP_FENCE: begin
        if (f3 != 3'd0) c.trap = rvex_pkg::TRAP_ILLEGAL;
      end
      rvex_pkg::OP_SYSTEM: begin
        if (insn_i == rvex_pkg::INSN_EBREAK) c.trap = rvex_pkg::TRAP_EBREAK;
        else if (insn_i == rvex_pkg::INSN_ECALL || insn_i == rvex_pkg::INSN_MRET)
          c.trap = rvex_pkg::TRAP_SYSTEM;
        else if (f3 != 3'd0 && f3 != 3'd4) c.trap = rvex_pkg::TRAP_SYSTEM;
        else c.trap = rvex_pkg::TRAP_ILLEGAL;
      end
      default: c.trap = rvex_pkg::TRAP_ILLEGAL;
    endcase
    // traps suppress everything but status
    if (c.trap != rvex_pkg::TRAP_NONE) begin
      c.wr = 1'b0; c.alu_val = '0; c.npc = pc_i; c.kind = rvex_pkg::MEM_NONE;
      c.size = 2'd0; c.uns = 1'b0; c.addr = '0; c.sdata = '0;
      c.sel = rvex_pkg::RES_ALU;
    end
    c.rd_out = c.wr || (c.kind == rvex_pkg::MEM_LOAD);
    c.wr = c.wr && (c.rd != 5'd0);
    ctrl_o = c;
  end

endmodule

// ===== design/rvex_mul.sv =====
// ----------------------------------------------------------------------------
// rvex_mul
// Three-stage 64x64 multiplier built from 32x32 partial products; gives the low
// and high halves with the mulh/mulhsu corrections.
// ----------------------------------------------------------------------------
module rvex_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [1:0]  mode_i,
  output logic [63:0] lo_o,
  output logic [63:0] hi_o
);

  logic [63:0]  a1_q, b1_q, ll_q, lh_q, hl_q, hh_q;
  logic [1:0]   m1_q;
  logic [127:0] p_d, p_q;
  logic [63:0]  a2_q, b2_q, corr;
  logic [1:0]   m2_q;

  // stage 1: partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[31:0] * b_i[31:0];
      lh_q <= a_i[31:0] * b_i[63:32];
      hl_q <= a_i[63:32] * b_i[31:0];
      hh_q <= a_i[63:32] * b_i[63:32];
      a1_q <= a_i;
      b1_q <= b_i;
      m1_q <= mode_i;
    end
  end

  // stage 2: sum of partial products
  assign p_d = {hh_q, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0};
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= p_d;
      a2_q <= a1_q;
      b2_q <= b1_q;
      m2_q <= m1_q;
    end
  end

  // stage 3: signed corrections of the high half
  always_comb begin
    corr = '0;
    if (m2_q != 2'd0 && a2_q[63]) corr = b2_q;
    if (m2_q == 2'd1 && b2_q[63]) corr = corr + a2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_o <= p_q[63:0];
      hi_o <= p_q[127:64] - corr;
    end
  end

endmodule

// ===== design/rvex_div.sv =====
// ----------------------------------------------------------------------------
// rvex_div
// Pipelined radix-2 restoring divider: one quotient bit per stage, sign and
// corner cases handled at the ends.
// ----------------------------------------------------------------------------
module rvex_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        signed_i,
  output logic [63:0] quo_o,
  output logic [63:0] rem_o
);

  localparam int unsigned N = rvex_pkg::DivSteps;

  logic [63:0] rem_q [N+1];
  logic [63:0] quo_q [N+1];
  logic [63:0] dvs_q [N+1];
  logic        nq_q  [N+1];
  logic        nr_q  [N+1];
  logic        z_q   [N+1];
  logic        ov_q  [N+1];
  logic [63:0] a0_q  [N+1];

  logic [63:0] ma, mb;
  assign ma = (signed_i && a_i[63]) ? 64'd0 - a_i : a_i;
  assign mb = (signed_i && b_i[63]) ? 64'd0 - b_i : b_i;

  // entry stage: magnitudes and special flags
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= ma;
      dvs_q[0] <= mb;
      nq_q[0]  <= signed_i && (a_i[63] ^ b_i[63]);
      nr_q[0]  <= signed_i && a_i[63];
      z_q[0]   <= b_i == 64'd0;
      ov_q[0]  <= signed_i && a_i == 64'h8000_0000_0000_0000 && b_i == '1;
      a0_q[0]  <= a_i;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < N; s++) begin : g_step
    logic [64:0] sh;
    logic [64:0] df;
    assign sh = {rem_q[s], quo_q[s][63]};
    assign df = sh - {1'b0, dvs_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!df[64]) begin
          rem_q[s+1] <= df[63:0];
          quo_q[s+1] <= {quo_q[s][62:0], 1'b1};
        end else begin
          rem_q[s+1] <= sh[63:0];
          quo_q[s+1] <= {quo_q[s][62:0], 1'b0};
        end
        dvs_q[s+1] <= dvs_q[s];
        nq_q[s+1]  <= nq_q[s];
        nr_q[s+1]  <= nr_q[s];
        z_q[s+1]   <= z_q[s];
        ov_q[s+1]  <= ov_q[s];
        a0_q[s+1]  <= a0_q[s];
      end
    end
  end

  // exit stage: signs and corner cases
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_q[N]) begin
        quo_o <= '1;
        rem_o <= a0_q[N];
      end else if (ov_q[N]) begin
        quo_o <= a0_q[N];
        rem_o <= '0;
      end else begin
        quo_o <= nq_q[N] ? 64'd0 - quo_q[N] : quo_q[N];
        rem_o <= nr_q[N] ? 64'd0 - rem_q[N] : rem_q[N];
      end
    end
  end

endmodule

// ===== design/rv64im_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// rv64im_execute_unit_top
// RV64IM execute pipeline: decode/ALU, multiplier and divider stages, one
// result item per instruction item.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle is accepted unless the master side stalls;
// results leave in order through the divider's entry stage, its 64 step stages
// and its exit stage, plus the output register; decode feeds the entry stage
// directly. The whole pipe advances together; a stall on the master side holds
// every stage.
module rv64im_execute_unit_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: instruction[31:0], pc[95:32], rs1_value[159:96], rs2_value[223:160]
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: dest_index[4:0], dest_write[5], dest_value[69:6], next_pc[133:70],
  // mem_kind[135:134], mem_size_log2[137:136], load_unsigned[138],
  // mem_address[202:139], store_data[266:203], trap_status[268:267], zero fill
  output logic [271:0] m_axis_tdata
);

  localparam int unsigned Lat = rvex_pkg::DivSteps + 2;

  logic            en;
  rvex_pkg::ctrl_t dec;
  rvex_pkg::ctrl_t ctl_q [Lat+1];
  logic [Lat:0]    vld_q;
  logic [63:0]     mlo, mhi, quo, rem;
  logic [63:0]     mlo_q [Lat-3];
  logic [63:0]     mhi_q [Lat-3];
  logic [63:0]     val;
  logic [271:0]    out_q;
  logic            ovld_q;

  // pipe advances when the output slot is free or being taken
  assign en = !ovld_q || m_axis_tready;
  assign s_axis_tready = en;

  rvex_decode u_dec (
    .insn_i (s_axis_tdata[31:0]),
    .pc_i   (s_axis_tdata[95:32]),
    .a_i    (s_axis_tdata[159:96]),
    .b_i    (s_axis_tdata[223:160]),
    .ctrl_o (dec)
  );

  rvex_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (dec.op_a),
    .b_i    (dec.op_b),
    .mode_i (dec.mulh_mode),
    .lo_o   (mlo),
    .hi_o   (mhi)
  );

  rvex_div u_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .a_i      (dec.op_a),
    .b_i      (dec.op_b),
    .signed_i (dec.div_signed),
    .quo_o    (quo),
    .rem_o    (rem)
  );

  // control shift line
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= dec;
      for (int i = 0; i < Lat; i++) ctl_q[i+1] <= ctl_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-1:0], s_axis_tvalid};
    end
  end

  // delay multiplier results to line up with the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      mlo_q[0] <= mlo;
      mhi_q[0] <= mhi;
      for (int i = 0; i < Lat - 4; i++) begin
        mlo_q[i+1] <= mlo_q[i];
        mhi_q[i+1] <= mhi_q[i];
      end
    end
  end

  // result select
  always_comb begin
    rvex_pkg::ctrl_t c;
    logic [63:0] r;
    c = ctl_q[Lat-1];
    case (c.sel)
      rvex_pkg::RES_MULL: r = mlo_q[Lat-4];
      rvex_pkg::RES_MULH: r = mhi_q[Lat-4];
      rvex_pkg::RES_DIV:  r = quo;
      rvex_pkg::RES_REM:  r = rem;
      default:            r = c.alu_val;
    endcase
    if (c.word) r = {{32{r[31]}}, r[31:0]};
    val = c.wr ? r : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (en) begin
      ovld_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {3'd0, ctl_q[Lat-1].trap, ctl_q[Lat-1].sdata, ctl_q[Lat-1].addr,
                ctl_q[Lat-1].uns, ctl_q[Lat-1].size, ctl_q[Lat-1].kind,
                ctl_q[Lat-1].npc, val, ctl_q[Lat-1].wr,
                ctl_q[Lat-1].rd_out ? ctl_q[Lat-1].rd : 5'd0};
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  logic unused;
  assign unused = ^{vld_q[Lat], ctl_q[Lat]};

endmodule

// ===== design/rvex_checker.sv =====
// ----------------------------------------------------------------------------
// rvex_checker
// Port-level checks on the execute pipeline.
// ----------------------------------------------------------------------------
module rvex_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [271:0] m_axis_tdata
);

  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // never a write to register zero
  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4:0] != 5'd0)
    else $error("write to x0");

  // trap items carry no write and no memory access
  a_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[268:267] != 2'd0 |->
      !m_axis_tdata[5] && m_axis_tdata[135:134] == 2'd0)
    else $error("trap with side effect");

  // input side ready whenever output is free
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("stall with empty output");

  logic unused;
  assign unused = s_axis_tvalid;

endmodule

bind rv64im_execute_unit_top rvex_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
